/* sv/fbc_pkg.sv */
// fbc_pkg: shared types and constants of the frustum box classifier.
// Depends on nothing; used by every module under sv/.

package fbc_pkg;

    // Planes that take part in the test (the first NUM_PLANES of the list)
    localparam int NUM_PLANES = 6;
    // Plane registers held by the configuration port
    localparam int REG_COUNT  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int COORD_W  = 16;  // signed Q11.4
    localparam int EXTENT_W = 15;  // unsigned Q11.4
    localparam int COMP_W   = 16;  // plane component, signed
    localparam int OFF_SHIFT = 14; // brings Q11.4 offset to the 2^18 product scale

    localparam int PROD_C_W = 2 * COMP_W;          // signed n * c
    localparam int PROD_E_W = COMP_W + EXTENT_W;   // unsigned |n| * e
    localparam int DIST_W   = PROD_C_W + 2;        // sum of three signed products
    localparam int RAD_W    = PROD_E_W + 2;        // sum of three unsigned products
    localparam int OFFS_W   = COMP_W + OFF_SHIFT;  // scaled offset
    localparam int TEST_W   = DIST_W + 2;          // dist +/- rad + offset

    localparam int CLASS_W = 2;
    localparam logic [CLASS_W-1:0] CLASS_INSIDE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_CROSSING = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OUTSIDE  = 2'd2;

    // Register word layout: offset in the top quarter, normal x in the bottom
    typedef struct packed {
        logic signed [COMP_W-1:0] off;
        logic signed [COMP_W-1:0] nz;
        logic signed [COMP_W-1:0] ny;
        logic signed [COMP_W-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic outside;
        logic crossing;
    } lane_flags_t;

endpackage

/* sv/fbc_plane_lane.sv */
// fbc_plane_lane: three-stage test of one box against one plane.
// Depends on fbc_pkg.

module fbc_plane_lane
(
    input  logic                                 clk,
    input  fbc_pkg::plane_t                      plane,
    input  logic signed [fbc_pkg::COORD_W-1:0]   center_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]   center_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]   center_z,
    input  logic        [fbc_pkg::EXTENT_W-1:0]  extent_x,
    input  logic        [fbc_pkg::EXTENT_W-1:0]  extent_y,
    input  logic        [fbc_pkg::EXTENT_W-1:0]  extent_z,
    output fbc_pkg::lane_flags_t                 flags
);

    logic signed [fbc_pkg::COMP_W-1:0]   comp   [3];
    logic        [fbc_pkg::COMP_W-1:0]   mag    [3];
    logic signed [fbc_pkg::COORD_W-1:0]  coord  [3];
    logic        [fbc_pkg::EXTENT_W-1:0] ext    [3];

    logic signed [fbc_pkg::PROD_C_W-1:0] pc_reg [3];
    logic signed [fbc_pkg::PROD_C_W-1:0] pc_next [3];
    logic        [fbc_pkg::PROD_E_W-1:0] pe_reg [3];
    logic        [fbc_pkg::PROD_E_W-1:0] pe_next [3];
    logic signed [fbc_pkg::COMP_W-1:0]   off1_reg;

    logic signed [fbc_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic        [fbc_pkg::RAD_W-1:0]    rad_reg, rad_next;
    logic signed [fbc_pkg::OFFS_W-1:0]   offs_reg, offs_next;

    logic signed [fbc_pkg::TEST_W-1:0]   upper, lower;
    fbc_pkg::lane_flags_t                flags_reg, flags_next;

    // Stage 1: products; the magnitude of -2^15 is 2^15, exact in 16 unsigned bits
    always_comb
    begin
        comp[0]  = plane.nx;
        comp[1]  = plane.ny;
        comp[2]  = plane.nz;
        coord[0] = center_x;
        coord[1] = center_y;
        coord[2] = center_z;
        ext[0]   = extent_x;
        ext[1]   = extent_y;
        ext[2]   = extent_z;
        for (int i = 0; i < 3; i++)
        begin
            mag[i]     = comp[i][fbc_pkg::COMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
            pc_next[i] = fbc_pkg::PROD_C_W'(comp[i]) * fbc_pkg::PROD_C_W'(coord[i]);
            pe_next[i] = fbc_pkg::PROD_E_W'(mag[i]) * fbc_pkg::PROD_E_W'(ext[i]);
        end
    end

    // Stage 2: centre distance, projected radius, scaled offset
    always_comb
    begin
        dist_next = fbc_pkg::DIST_W'(pc_reg[0]) + fbc_pkg::DIST_W'(pc_reg[1])
                  + fbc_pkg::DIST_W'(pc_reg[2]);
        rad_next  = fbc_pkg::RAD_W'(pe_reg[0]) + fbc_pkg::RAD_W'(pe_reg[1])
                  + fbc_pkg::RAD_W'(pe_reg[2]);
        offs_next = $signed({off1_reg, {fbc_pkg::OFF_SHIFT{1'b0}}});
    end

    // Stage 3: sign tests of both box corners against the plane
    always_comb
    begin
        upper = fbc_pkg::TEST_W'(dist_reg)
              + $signed({{(fbc_pkg::TEST_W-fbc_pkg::RAD_W){1'b0}}, rad_reg})
              + fbc_pkg::TEST_W'(offs_reg);
        lower = fbc_pkg::TEST_W'(dist_reg)
              - $signed({{(fbc_pkg::TEST_W-fbc_pkg::RAD_W){1'b0}}, rad_reg})
              + fbc_pkg::TEST_W'(offs_reg);
        flags_next.outside  = upper[fbc_pkg::TEST_W-1];
        flags_next.crossing = lower[fbc_pkg::TEST_W-1];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pc_reg[i] <= pc_next[i];
            pe_reg[i] <= pe_next[i];
        end
        off1_reg  <= plane.off;
        dist_reg  <= dist_next;
        rad_reg   <= rad_next;
        offs_reg  <= offs_next;
        flags_reg <= flags_next;
    end

    assign flags = flags_reg;

endmodule

/* sv/fbc_classify.sv */
// fbc_classify: merges the per-plane flags into one class and registers the result.
// Depends on fbc_pkg.

module fbc_classify
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    input  fbc_pkg::lane_flags_t [fbc_pkg::NUM_PLANES-1:0]   flags,
    output logic                                             done,
    output logic [fbc_pkg::CLASS_W-1:0]                      box_class
);

    logic                          any_out, any_cross;
    logic                          done_reg;
    logic [fbc_pkg::CLASS_W-1:0]   class_reg, class_next;

    // Outside on any plane wins over crossing on an earlier one
    always_comb
    begin
        any_out   = 1'b0;
        any_cross = 1'b0;
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            any_out   = any_out   | flags[p].outside;
            any_cross = any_cross | flags[p].crossing;
        end
        if (any_out)
            class_next = fbc_pkg::CLASS_OUTSIDE;
        else if (any_cross)
            class_next = fbc_pkg::CLASS_CROSSING;
        else
            class_next = fbc_pkg::CLASS_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    assign done      = done_reg;
    assign box_class = class_reg;

endmodule

/* sv/frustum_box_classifier.sv */
// frustum_box_classifier: top level, plane registers, lane array and valid pipeline.
// Depends on fbc_pkg, fbc_plane_lane and fbc_classify.

// Classifies one axis-aligned box (centre and half-extents, Q11.4) against
// the frustum planes each clock cycle. Pulse start with the box on the
// centre and extent ports; busy is always low, so a new box may be offered
// on every cycle. The class appears on box_class once the box has passed
// the pipeline, qualified by a one-cycle done pulse; hold nothing back,
// as the receiver cannot stall the block and each word must be captured in
// the cycle it is shown. The pipeline stages are products, sums, sign
// tests, then the merge of all planes into one class. Load the
// six plane words through cfg_we/cfg_index/cfg_data while no box is in
// flight; an index beyond the last plane is dropped. After reset all planes
// are zero and every box reads as inside.

module frustum_box_classifier
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [fbc_pkg::COORD_W-1:0]      center_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]      center_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]      center_z,
    input  logic        [fbc_pkg::EXTENT_W-1:0]     extent_x,
    input  logic        [fbc_pkg::EXTENT_W-1:0]     extent_y,
    input  logic        [fbc_pkg::EXTENT_W-1:0]     extent_z,
    output logic                                    done,
    output logic        [fbc_pkg::CLASS_W-1:0]      box_class,
    input  logic                                    cfg_we,
    input  logic        [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic        [fbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fbc_pkg::plane_t                                 plane_reg [fbc_pkg::REG_COUNT];
    fbc_pkg::lane_flags_t [fbc_pkg::NUM_PLANES-1:0]  lane_flags;
    logic                                            accept;
    // One valid bit per lane stage: products, sums, sign tests
    logic                 [2:0]                      vld_reg;

    // Every cycle is open for a new box
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Plane registers: write the addressed word, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::REG_COUNT; i++)
                plane_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < fbc_pkg::REG_COUNT; i++)
            begin
                if (cfg_we && cfg_index == fbc_pkg::CFG_IDX_W'(i))
                    plane_reg[i] <= fbc_pkg::plane_t'(cfg_data);
            end
        end
    end

    // Advance the valid bit alongside the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], accept};
    end

    // One lane per active plane, all fed the same box
    for (genvar p = 0; p < fbc_pkg::NUM_PLANES; p++)
    begin : g_lane
        fbc_plane_lane u_lane
        (
            .clk      (clk),
            .plane    (plane_reg[p]),
            .center_x (center_x),
            .center_y (center_y),
            .center_z (center_z),
            .extent_x (extent_x),
            .extent_y (extent_y),
            .extent_z (extent_z),
            .flags    (lane_flags[p])
        );
    end

    fbc_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[2]),
        .flags     (lane_flags),
        .done      (done),
        .box_class (box_class)
    );

endmodule

/* dv/frustum_box_classifier_test.sv */
// frustum_box_classifier_test: self-checking bench for the frustum box classifier.
// Holds its own plane registers and classifier, drives boxes and plane loads.
// Depends on fbc_pkg and frustum_box_classifier from sv/.

module frustum_box_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth of the block: products, sums, sign tests, merge
    localparam int PIPE_DEPTH = 4;
    // Row marker: the class is worked out by the bench's own classifier
    localparam int BY_PREDICTOR = -1;
    localparam int RANDOM_PHASES = 8;
    localparam int BOXES_PER_PHASE = 50;
    // Chance in a hundred of a gap before a box
    localparam int GAP_CHANCE = 18;

    typedef struct packed {
        logic signed [fbc_pkg::COORD_W-1:0]  cx;
        logic signed [fbc_pkg::COORD_W-1:0]  cy;
        logic signed [fbc_pkg::COORD_W-1:0]  cz;
        logic        [fbc_pkg::EXTENT_W-1:0] ex;
        logic        [fbc_pkg::EXTENT_W-1:0] ey;
        logic        [fbc_pkg::EXTENT_W-1:0] ez;
    } box_t;

    typedef enum {ROW_BOX, ROW_PLANE} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [fbc_pkg::CFG_IDX_W-1:0]      index;
        logic [fbc_pkg::CFG_DATA_W-1:0]     word;
        box_t                               box;
        int                                 known_class;
    } stim_row_t;

    typedef struct {
        int unsigned                        box_no;
        logic [fbc_pkg::CLASS_W-1:0]        verdict;
    } pending_class_t;

    typedef enum {
        PLANES_FRUSTUM, PLANES_RANDOM, PLANES_ZERO,
        PLANES_MIN, PLANES_MAX, PLANES_ONES
    } plane_style_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [fbc_pkg::COORD_W-1:0]     center_x;
    logic signed [fbc_pkg::COORD_W-1:0]     center_y;
    logic signed [fbc_pkg::COORD_W-1:0]     center_z;
    logic [fbc_pkg::EXTENT_W-1:0]           extent_x;
    logic [fbc_pkg::EXTENT_W-1:0]           extent_y;
    logic [fbc_pkg::EXTENT_W-1:0]           extent_z;
    logic                                   done;
    logic [fbc_pkg::CLASS_W-1:0]            box_class;
    logic                                   cfg_we;
    logic [fbc_pkg::CFG_IDX_W-1:0]          cfg_index;
    logic [fbc_pkg::CFG_DATA_W-1:0]         cfg_data;

    // Bench copy of the plane registers, updated as each load is issued
    fbc_pkg::plane_t        frustum_planes [fbc_pkg::REG_COUNT];
    pending_class_t         pending_classes [$];
    stim_row_t              directed_rows [$];

    int unsigned            boxes_sent;
    int unsigned            classes_seen;
    int unsigned            class_tally [3];
    int unsigned            failures;
    int                     gap_chance;

    always #6 clk = ~clk;

    frustum_box_classifier u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .extent_x   (extent_x),
        .extent_y   (extent_y),
        .extent_z   (extent_z),
        .done       (done),
        .box_class  (box_class),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Classify a box against the first NUM_PLANES planes. Every sum is taken
    // exactly in 64 bits; an outside plane ends the search, a crossing plane
    // only marks the box and the search goes on.
    function automatic logic [fbc_pkg::CLASS_W-1:0] classify_box(box_t b);
        longint signed centre_dist;
        longint signed radius;
        longint signed offs;
        longint signed mag_x;
        longint signed mag_y;
        longint signed mag_z;
        fbc_pkg::plane_t pl;
        logic [fbc_pkg::CLASS_W-1:0] verdict;
        verdict = fbc_pkg::CLASS_INSIDE;
        for (int p = 0; p < fbc_pkg::NUM_PLANES && p < fbc_pkg::REG_COUNT; p++)
        begin
            pl = frustum_planes[p];
            // the most negative component has magnitude 2^15, kept exactly here
            mag_x = (pl.nx < 0) ? -longint'(pl.nx) : longint'(pl.nx);
            mag_y = (pl.ny < 0) ? -longint'(pl.ny) : longint'(pl.ny);
            mag_z = (pl.nz < 0) ? -longint'(pl.nz) : longint'(pl.nz);
            centre_dist = longint'(b.cx) * longint'(pl.nx)
                        + longint'(b.cy) * longint'(pl.ny)
                        + longint'(b.cz) * longint'(pl.nz);
            radius = longint'(b.ex) * mag_x + longint'(b.ey) * mag_y
                   + longint'(b.ez) * mag_z;
            offs = longint'(pl.off) <<< fbc_pkg::OFF_SHIFT;
            if (centre_dist + radius + offs < 0)
            begin
                verdict = fbc_pkg::CLASS_OUTSIDE;
                break;
            end
            if (centre_dist - radius + offs < 0)
                verdict = fbc_pkg::CLASS_CROSSING;
        end
        return verdict;
    endfunction

    function automatic stim_row_t box_row(int cx, int cy, int cz, int ex, int ey, int ez,
                                          int known_class);
        stim_row_t r;
        r.kind = ROW_BOX;
        r.index = '0;
        r.word = '0;
        r.box.cx = 16'(cx);
        r.box.cy = 16'(cy);
        r.box.cz = 16'(cz);
        r.box.ex = 15'(ex);
        r.box.ey = 15'(ey);
        r.box.ez = 15'(ez);
        r.known_class = known_class;
        return r;
    endfunction

    function automatic stim_row_t plane_row(int index,
                                            logic [fbc_pkg::CFG_DATA_W-1:0] word);
        stim_row_t r;
        r.kind = ROW_PLANE;
        r.index = fbc_pkg::CFG_IDX_W'(index);
        r.word = word;
        r.box = '0;
        r.known_class = BY_PREDICTOR;
        return r;
    endfunction

    function automatic logic signed [fbc_pkg::COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic logic [fbc_pkg::EXTENT_W-1:0] corner_extent();
        case ($urandom_range(0, 3))
            0: return 15'd0;
            1: return 15'd32767;
            2: return 15'd1;
            default: return 15'd16384;
        endcase
    endfunction

    // Half the boxes are of scene scale, so that all three classes come up often;
    // the rest use the full range or the corners of each field.
    function automatic box_t random_box();
        box_t b;
        case ($urandom_range(0, 3))
            0:
            begin
                b.cx = 16'($urandom);
                b.cy = 16'($urandom);
                b.cz = 16'($urandom);
                b.ex = 15'($urandom);
                b.ey = 15'($urandom);
                b.ez = 15'($urandom);
            end
            3:
            begin
                b.cx = corner_coord();
                b.cy = corner_coord();
                b.cz = corner_coord();
                b.ex = corner_extent();
                b.ey = corner_extent();
                b.ez = corner_extent();
            end
            default:
            begin
                b.cx = 16'(int'($urandom_range(0, 4095)) - 2048);
                b.cy = 16'(int'($urandom_range(0, 4095)) - 2048);
                b.cz = 16'(int'($urandom_range(0, 4095)) - 2048);
                b.ex = 15'($urandom_range(0, 600));
                b.ey = 15'($urandom_range(0, 600));
                b.ez = 15'($urandom_range(0, 600));
            end
        endcase
        return b;
    endfunction

    function automatic logic [fbc_pkg::CFG_DATA_W-1:0] make_plane(plane_style_t style);
        fbc_pkg::plane_t pl;
        case (style)
            PLANES_FRUSTUM:
            begin
                // normals within +/-1.0, offsets mostly on the inner side
                pl.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
                pl.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
                pl.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
                pl.off = 16'(int'($urandom_range(0, 12000)) - 2000);
            end
            PLANES_RANDOM: pl = {$urandom, $urandom};
            PLANES_ZERO:   pl = '0;
            PLANES_MIN:    pl = {4{16'h8000}};
            PLANES_MAX:    pl = {4{16'h7FFF}};
            default:       pl = '1;
        endcase
        return pl;
    endfunction

    // Load one plane word; the block drops indexes beyond the list, so does the copy
    task automatic load_plane(logic [fbc_pkg::CFG_IDX_W-1:0] index,
                              logic [fbc_pkg::CFG_DATA_W-1:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= word;
        if (index < fbc_pkg::REG_COUNT)
            frustum_planes[index] = word;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop start and let the pipeline empty before the planes are touched
    task automatic drain_boxes();
        start <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // Offer one box, hold it until taken, then log the class it must produce
    task automatic send_box(box_t b, int known_class);
        pending_class_t entry;
        if (gap_chance > 0 && $urandom_range(0, 99) < gap_chance)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start    <= 1'b1;
        center_x <= b.cx;
        center_y <= b.cy;
        center_z <= b.cz;
        extent_x <= b.ex;
        extent_y <= b.ey;
        extent_z <= b.ez;
        do
            @(posedge clk);
        while (busy);
        entry.box_no = boxes_sent;
        if (known_class == BY_PREDICTOR)
            entry.verdict = classify_box(b);
        else
            entry.verdict = known_class[fbc_pkg::CLASS_W-1:0];
        pending_classes.push_back(entry);
        boxes_sent++;
    endtask

    // Result side: the block cannot be held off, so catch every done word
    // in the cycle it is shown and compare it with the oldest pending class.
    always @(posedge clk)
    begin
        pending_class_t head;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_classes.size() == 0)
            begin
                $error("box_class word with no box pending: actual %0d", box_class);
                failures++;
            end
            else
            begin
                head = pending_classes.pop_front();
                classes_seen++;
                if (box_class !== head.verdict)
                begin
                    $error("box %0d box_class: expected %0d, actual %0d",
                           head.box_no, head.verdict, box_class);
                    failures++;
                end
                else if (box_class < 3)
                    class_tally[box_class]++;
            end
        end
    end

    // Hard stop should the block hang
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        plane_style_t phase_style [RANDOM_PHASES];
        logic [fbc_pkg::CFG_DATA_W-1:0] spare_word;

        phase_style = '{PLANES_FRUSTUM, PLANES_RANDOM, PLANES_FRUSTUM, PLANES_ZERO,
                        PLANES_MIN, PLANES_FRUSTUM, PLANES_MAX, PLANES_ONES};

        boxes_sent   = 0;
        classes_seen = 0;
        failures     = 0;
        class_tally  = '{0, 0, 0};
        gap_chance   = GAP_CHANCE;
        foreach (frustum_planes[i])
            frustum_planes[i] = '0;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        center_x  <= '0;
        center_y  <= '0;
        center_z  <= '0;
        extent_x  <= '0;
        extent_y  <= '0;
        extent_z  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset every plane is zero and no box can fail a plane
        directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                        fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(32767, 32767, 32767, 0, 0, 0,
                                        fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(-1, 1, -32768, 1, 16384, 32767,
                                        fbc_pkg::CLASS_INSIDE));
        // Right plane x >= 0 with unit normal: clear out, straddling, touching both ways
        directed_rows.push_back(plane_row(0, 64'h0000_0000_0000_4000));
        directed_rows.push_back(box_row(-100, 0, 0, 10, 0, 0, fbc_pkg::CLASS_OUTSIDE));
        directed_rows.push_back(box_row(-5, 0, 0, 10, 0, 0, fbc_pkg::CLASS_CROSSING));
        directed_rows.push_back(box_row(100, 0, 0, 10, 0, 0, fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(-10, 0, 0, 10, 0, 0, fbc_pkg::CLASS_CROSSING));
        directed_rows.push_back(box_row(10, 0, 0, 10, 0, 0, fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(100, 32767, -32768, 10, 32767, 32767,
                                        fbc_pkg::CLASS_INSIDE));
        // Most negative normal component: its magnitude must not wrap
        directed_rows.push_back(plane_row(0, 64'h0000_0000_0000_8000));
        directed_rows.push_back(box_row(20, 0, 0, 10, 0, 0, fbc_pkg::CLASS_OUTSIDE));
        directed_rows.push_back(box_row(-20, 0, 0, 10, 0, 0, fbc_pkg::CLASS_INSIDE));
        directed_rows.push_back(box_row(5, 0, 0, 10, 0, 0, fbc_pkg::CLASS_CROSSING));
        // Indexes past the last plane are dropped: the class must not move
        directed_rows.push_back(plane_row(6, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(plane_row(7, 64'h8000_8000_8000_8000));
        directed_rows.push_back(box_row(20, 0, 0, 10, 0, 0, fbc_pkg::CLASS_OUTSIDE));
        // Offset alone decides a zero-normal plane
        directed_rows.push_back(plane_row(1, 64'hFFFF_0000_0000_0000));
        directed_rows.push_back(box_row(-20, 0, 0, 10, 0, 0, fbc_pkg::CLASS_OUTSIDE));
        directed_rows.push_back(plane_row(1, 64'h0001_0000_0000_0000));
        directed_rows.push_back(box_row(-20, 0, 0, 10, 0, 0, fbc_pkg::CLASS_INSIDE));
        // Last plane in the list takes part; outside on a later plane beats crossing
        directed_rows.push_back(plane_row(5, 64'h0000_4000_0000_0000));
        directed_rows.push_back(box_row(-20, 0, -50, 0, 0, 10, fbc_pkg::CLASS_OUTSIDE));
        directed_rows.push_back(box_row(-20, 0, -5, 0, 0, 10, fbc_pkg::CLASS_CROSSING));
        directed_rows.push_back(box_row(5, 0, -50, 10, 0, 10, fbc_pkg::CLASS_OUTSIDE));
        // Extreme plane words, boxes at the corners of the range
        directed_rows.push_back(plane_row(2, 64'h8000_8000_8000_8000));
        directed_rows.push_back(plane_row(3, 64'h7FFF_7FFF_7FFF_7FFF));
        directed_rows.push_back(plane_row(4, 64'h7FFF_8000_7FFF_8000));
        directed_rows.push_back(box_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                        BY_PREDICTOR));
        directed_rows.push_back(box_row(32767, 32767, 32767, 32767, 32767, 32767,
                                        BY_PREDICTOR));
        directed_rows.push_back(box_row(32767, -32768, 0, 0, 32767, 1, BY_PREDICTOR));

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_PLANE)
            begin
                drain_boxes();
                load_plane(directed_rows[r].index, directed_rows[r].word);
            end
            else
                send_box(directed_rows[r].box, directed_rows[r].known_class);
        end

        // Random part: reload all six planes per phase, then stream boxes.
        // One phase runs back to back with no gaps at all.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_boxes();
            for (int i = 0; i < fbc_pkg::REG_COUNT; i++)
                load_plane(fbc_pkg::CFG_IDX_W'(i), make_plane(phase_style[ph]));
            if ($urandom_range(0, 1) == 1)
            begin
                spare_word = {$urandom, $urandom};
                load_plane(fbc_pkg::CFG_IDX_W'($urandom_range(fbc_pkg::REG_COUNT, 7)),
                           spare_word);
            end
            gap_chance = (ph == 2) ? 0 : GAP_CHANCE;
            for (int n = 0; n < BOXES_PER_PHASE; n++)
                send_box(random_box(), BY_PREDICTOR);
        end

        // Let the last words come out, then allow a few spare cycles for strays
        start <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Classified %0d boxes over %0d plane sets: %0d inside, %0d crossing, %0d outside",
                 classes_seen, RANDOM_PHASES + 1, class_tally[fbc_pkg::CLASS_INSIDE],
                 class_tally[fbc_pkg::CLASS_CROSSING], class_tally[fbc_pkg::CLASS_OUTSIDE]);
        $display("Boxes offered %0d, mismatches %0d", boxes_sent, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
